// ===== design/assert_macros.svh =====
// Assertion macros used by lssf_checker, the port-level checker of this project.
// Clocked on clk; the first form is held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lssf_pkg.sv =====
// Package for the LED strip SPI framer: chip codes, register indexes,
// microcode word layout and the sequencer program. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lssf_pkg;

  // Supported chip types; codes above WS2801 behave as WS2801
  typedef enum logic [2:0] {
    CHIP_APA102  = 3'd0,
    CHIP_P9813   = 3'd1,
    CHIP_LPD6803 = 3'd2,
    CHIP_LPD8806 = 3'd3,
    CHIP_WS2801  = 3'd4
  } chip_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CHIP_TYPE  = 2'd0,
    REG_BPP        = 2'd1,
    REG_PIXEL_CNT  = 2'd2,
    REG_BRIGHTNESS = 2'd3
  } reg_idx_t;

  localparam int CFG_DATA_W = 9;
  localparam int LEN_W      = 6;

  localparam logic [7:0] APA_HDR_BASE = 8'hE0;
  localparam logic [7:0] END_FILL_ONE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  // Microprogram addresses
  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_START = 3'd1,
    ST_HDR   = 3'd2,
    ST_PIX   = 3'd3,
    ST_END   = 3'd4
  } step_t;

  // Byte source of a step
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_HDR  = 2'd1,
    SRC_CHAN = 2'd2,
    SRC_END  = 2'd3
  } src_t;

  // Repeat count source of a step
  typedef enum logic [1:0] {
    LEN_START = 2'd0,
    LEN_HDR   = 2'd1,
    LEN_BPP   = 2'd2,
    LEN_END   = 2'd3
  } len_t;

  // Jump condition: wait for an input transfer, or run out the count
  typedef enum logic {
    JMP_INPUT = 1'b0,
    JMP_COUNT = 1'b1
  } jmp_t;

  typedef struct packed {
    src_t  src;
    len_t  len_sel;
    jmp_t  jmp;
    logic  mark_item;  // flag the step's last byte as last of the item
    logic  mark_done;  // step's last byte closes the frame
    logic  upd_idx;    // advance the pixel index when the step finishes
    step_t next;
  } ctrl_t;

  // Per-item frame figures, from the calc block to the sequencer
  typedef struct packed {
    logic [LEN_W-1:0] start_len;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] bpp_len;
    logic [LEN_W-1:0] end_len;
    logic [7:0]       hdr_byte;
    logic [7:0]       end_byte;
    logic             last;
  } frame_t;

  // Sequencer program
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      ST_WAIT:  w = '{SRC_ZERO, LEN_START, JMP_INPUT, 1'b0, 1'b0, 1'b0, ST_START};
      ST_START: w = '{SRC_ZERO, LEN_START, JMP_COUNT, 1'b0, 1'b0, 1'b0, ST_HDR};
      ST_HDR:   w = '{SRC_HDR,  LEN_HDR,   JMP_COUNT, 1'b0, 1'b0, 1'b0, ST_PIX};
      ST_PIX:   w = '{SRC_CHAN, LEN_BPP,   JMP_COUNT, 1'b1, 1'b0, 1'b0, ST_END};
      ST_END:   w = '{SRC_END,  LEN_END,   JMP_COUNT, 1'b1, 1'b1, 1'b1, ST_WAIT};
      default:  w = '{SRC_ZERO, LEN_START, JMP_INPUT, 1'b0, 1'b0, 1'b0, ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/lssf_frame_calc.sv =====
// Frame figures for one pixel: start/header/end lengths, header and fill
// bytes, last-pixel flag. Uses lssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lssf_frame_calc
  import lssf_pkg::*;
#(
  parameter int MAX_PIXELS = 256,
  parameter int IDX_W      = 8
) (
  input  wire logic [2:0]       chip_type,
  input  wire logic [2:0]       bytes_per_pixel,
  input  wire logic [8:0]       pixel_count,
  input  wire logic [4:0]       global_brightness,
  input  wire logic [7:0]       ch0,
  input  wire logic [7:0]       ch1,
  input  wire logic [7:0]       ch2,
  input  wire logic [IDX_W-1:0] pixel_index,
  output frame_t                frame
);

  localparam logic [8:0] MAX_N = 9'(MAX_PIXELS);

  chip_t      chip;
  logic [8:0] npix;
  logic [9:0] n_up32;
  logic [9:0] n_up16;
  logic [9:0] n_up8;
  logic [LEN_W-1:0] ceil32;
  logic [LEN_W-1:0] ceil16;
  logic [LEN_W-1:0] ceil8;
  logic       first;

  // Clamp registers into their working ranges
  always_comb begin
    if (chip_type > CHIP_WS2801) chip = CHIP_WS2801;
    else                         chip = chip_t'(chip_type);
    if (pixel_count == 9'd0)     npix = 9'd1;
    else if (pixel_count > MAX_N) npix = MAX_N;
    else                         npix = pixel_count;
  end

  // Rounded-up pixel counts by 32, 16, 8
  assign n_up32 = {1'b0, npix} + 10'd31;
  assign n_up16 = {1'b0, npix} + 10'd15;
  assign n_up8  = {1'b0, npix} + 10'd7;
  assign ceil32 = LEN_W'(n_up32[9:5]);
  assign ceil16 = LEN_W'(n_up16[9:4]);
  assign ceil8  = LEN_W'(n_up8[9:3]);

  assign first = (pixel_index == '0);

  always_comb begin
    frame = '0;
    frame.last = (10'(pixel_index) + 10'd1) >= {1'b0, npix};

    if (bytes_per_pixel < 3'd2)      frame.bpp_len = LEN_W'(2);
    else if (bytes_per_pixel > 3'd4) frame.bpp_len = LEN_W'(4);
    else                             frame.bpp_len = LEN_W'(bytes_per_pixel);

    // Start frame
    if (first) begin
      case (chip)
        CHIP_LPD8806: frame.start_len = ceil32;
        CHIP_WS2801:  frame.start_len = '0;
        default:      frame.start_len = LEN_W'(4);
      endcase
    end

    // Pixel header
    case (chip)
      CHIP_APA102: begin
        frame.hdr_len  = LEN_W'(1);
        frame.hdr_byte = APA_HDR_BASE | {3'b000, global_brightness};
      end
      CHIP_P9813: begin
        frame.hdr_len  = LEN_W'(1);
        frame.hdr_byte = {2'b11, ~ch0[7:6], ~ch1[7:6], ~ch2[7:6]};
      end
      default: begin
        frame.hdr_len  = '0;
        frame.hdr_byte = ZERO_BYTE;
      end
    endcase

    // End frame
    frame.end_byte = (chip == CHIP_LPD8806) ? END_FILL_ONE : ZERO_BYTE;
    if (frame.last) begin
      case (chip)
        CHIP_APA102:  frame.end_len = ceil16;
        CHIP_LPD6803: frame.end_len = ceil8;
        CHIP_LPD8806: frame.end_len = ceil32;
        CHIP_P9813:   frame.end_len = LEN_W'(4);
        default:      frame.end_len = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/led_strip_spi_framer_core.sv =====
// Top level of the LED strip SPI framer: config registers, microcoded
// byte sequencer and output register. Uses lssf_pkg and lssf_frame_calc.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel (two to four channel bytes) per input transfer and emits
// the wire bytes for a two-wire clocked LED strip, one byte per output
// transfer: start frame on the first pixel, a per-pixel header for APA102
// and P9813, the channel bytes, and the end frame on the last pixel. One
// pixel is taken at a time. A short microprogram of five steps (wait, start,
// header, pixel, end) runs the datapath; a step emits one byte per cycle
// while the output is not stalled, and a step with nothing to send emits
// no byte. m_tlast marks the final byte of the frame, m_tuser[0] the last
// byte of a pixel's channel bytes and the final byte of the end frame.

module led_strip_spi_framer_core
  import lssf_pkg::*;
#(
  parameter int MAX_PIXELS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,   // channel_0, channel_1, channel_2, channel_3
  // wire byte output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // wire_byte
  output logic                       m_tlast,   // frame_done
  output logic [0:0]                 m_tuser    // item_last
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  // Configuration registers
  logic [2:0] chip_type;
  logic [2:0] bytes_per_pixel;
  logic [8:0] pixel_count;
  logic [4:0] global_brightness;

  // Sequencer and datapath state
  step_t            pc, pc_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] pixel_index, pixel_index_next;
  logic [7:0]       ch [4];

  ctrl_t            cw;
  frame_t           frame;
  logic [LEN_W-1:0] len;
  logic             slot_free;
  logic             step_last;
  logic             emit;
  logic             load_ch;
  logic [7:0]       out_byte;
  logic             out_done;
  logic             out_item;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_type         <= 3'd0;
      bytes_per_pixel   <= 3'd3;
      pixel_count       <= 9'd1;
      global_brightness <= 5'd31;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_CHIP_TYPE:  chip_type         <= cfg_data[2:0];
        REG_BPP:        bytes_per_pixel   <= cfg_data[2:0];
        REG_PIXEL_CNT:  pixel_count       <= cfg_data[8:0];
        REG_BRIGHTNESS: global_brightness <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  lssf_frame_calc #(
    .MAX_PIXELS (MAX_PIXELS),
    .IDX_W      (IDX_W)
  ) u_calc (
    .chip_type         (chip_type),
    .bytes_per_pixel   (bytes_per_pixel),
    .pixel_count       (pixel_count),
    .global_brightness (global_brightness),
    .ch0               (ch[0]),
    .ch1               (ch[1]),
    .ch2               (ch[2]),
    .pixel_index       (pixel_index),
    .frame             (frame)
  );

  // Control word fetch and repeat count
  assign cw = ucode(pc);

  always_comb begin
    case (cw.len_sel)
      LEN_START: len = frame.start_len;
      LEN_HDR:   len = frame.hdr_len;
      LEN_BPP:   len = frame.bpp_len;
      LEN_END:   len = frame.end_len;
      default:   len = '0;
    endcase
  end

  assign slot_free = !m_tvalid || m_tready;
  assign step_last = (cnt + LEN_W'(1)) == len;
  assign s_tready  = (cw.jmp == JMP_INPUT);

  // Next step, repeat counter and pixel index
  always_comb begin
    pc_next          = pc;
    cnt_next         = cnt;
    pixel_index_next = pixel_index;
    emit             = 1'b0;
    load_ch          = 1'b0;
    case (cw.jmp)
      JMP_INPUT: begin
        if (s_tvalid) begin
          load_ch  = 1'b1;
          pc_next  = cw.next;
          cnt_next = '0;
        end
      end
      JMP_COUNT: begin
        if (len == '0) begin
          pc_next  = cw.next;
          cnt_next = '0;
        end else if (slot_free) begin
          emit = 1'b1;
          if (step_last) begin
            pc_next  = cw.next;
            cnt_next = '0;
          end else begin
            cnt_next = cnt + LEN_W'(1);
          end
        end
        if (cw.upd_idx && (pc_next != pc)) begin
          pixel_index_next = frame.last ? '0 : pixel_index + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Byte and flags of the current step
  always_comb begin
    case (cw.src)
      SRC_ZERO: out_byte = ZERO_BYTE;
      SRC_HDR:  out_byte = frame.hdr_byte;
      SRC_CHAN: out_byte = ch[cnt[1:0]];
      SRC_END:  out_byte = frame.end_byte;
      default:  out_byte = ZERO_BYTE;
    endcase
    out_item = cw.mark_item && step_last;
    out_done = out_item && frame.last && (cw.mark_done || (frame.end_len == '0));
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= ST_WAIT;
      cnt         <= '0;
      pixel_index <= '0;
    end else begin
      pc          <= pc_next;
      cnt         <= cnt_next;
      pixel_index <= pixel_index_next;
    end
  end

  // Pixel latch
  always_ff @(posedge clk) begin
    if (load_ch) begin
      ch[0] <= s_tdata[7:0];
      ch[1] <= s_tdata[15:8];
      ch[2] <= s_tdata[23:16];
      ch[3] <= s_tdata[31:24];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata    <= out_byte;
      m_tlast    <= out_done;
      m_tuser[0] <= out_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/lssf_checker.sv =====
// Port-level checks for led_strip_spi_framer_core, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lssf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic [0:0] m_tuser
);

  // stalled output byte holds
  `ASSERT_ON(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed while stalled")

  // end of frame is always also end of an item
  `ASSERT_ON(a_done_is_item, m_tvalid && m_tlast |-> m_tuser[0], "frame end without item end")

  // one pixel at a time: busy right after an input transfer
  `ASSERT_ON(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

  // reset leaves an empty output and a ready input
  `ASSERT_ALWAYS(a_reset_state, rst |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind led_strip_spi_framer_core lssf_checker u_lssf_checker (.*);

`default_nettype wire

// ===== dv/lssf_frame_checker.sv =====
// Wire-byte checker for the LED strip SPI framer: tracks the config port,
// predicts the byte stream of each accepted pixel and compares the output.
// Depends on lssf_pkg for chip codes, register indexes and byte constants.
`timescale 1ns / 1ps

module lssf_frame_checker
  import lssf_pkg::*;
#(
  parameter int MAX_PIX = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [31:0]           s_tdata,   // channel_0, channel_1, channel_2, channel_3
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,   // wire_byte
  input  logic                  m_tlast,   // frame_done
  input  logic [0:0]            m_tuser,   // item_last
  output int                    fail_count,
  output int                    pending,
  output int                    bytes_checked,
  output int                    frames_closed
);

  // top two header bits of a P9813 pixel
  localparam logic [1:0] P9813_HDR_TOP = 2'b11;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_done;
    logic       item_last;
  } wire_beat_t;

  wire_beat_t byte_q[$];

  // shadow of the config registers and the frame position
  logic [2:0] chip_reg;
  logic [2:0] bpp_reg;
  logic [8:0] count_reg;
  logic [4:0] bright_reg;
  logic [7:0] pix_pos;
  int         fails;
  int         checked;
  int         frames;

  // Expected wire bytes for one pixel, appended to byte_q
  task automatic frame_pixel(input logic [31:0] d);
    logic [7:0] ch [4];
    logic [7:0] beats [$];
    chip_t      kind;
    int         bpp;
    int         npix;
    int         chan_end;
    bit         closes;
    wire_beat_t b;
    for (int i = 0; i < 4; i++) ch[i] = d[8*i +: 8];
    // codes above WS2801 behave as WS2801; sizes are clamped
    kind = (chip_reg > CHIP_WS2801) ? CHIP_WS2801 : chip_t'(chip_reg);
    bpp  = (bpp_reg < 3'd2) ? 2 : (bpp_reg > 3'd4) ? 4 : int'(bpp_reg);
    npix = (count_reg == 9'd0) ? 1 : (int'(count_reg) > MAX_PIX) ? MAX_PIX : int'(count_reg);

    // start frame on the first pixel
    if (pix_pos == 8'd0) begin
      if (kind == CHIP_LPD8806) repeat ((npix + 31) / 32) beats.push_back(ZERO_BYTE);
      else if (kind != CHIP_WS2801) repeat (4) beats.push_back(ZERO_BYTE);
    end

    // per-pixel header; P9813 always looks at channel 2
    case (kind)
      CHIP_APA102: beats.push_back(APA_HDR_BASE | {3'b000, bright_reg});
      CHIP_P9813:  beats.push_back({P9813_HDR_TOP, ~ch[0][7:6], ~ch[1][7:6], ~ch[2][7:6]});
      default: ;
    endcase
    for (int i = 0; i < bpp; i++) beats.push_back(ch[i]);
    chan_end = beats.size() - 1;

    // index at or past the last pixel closes the frame
    closes = (int'(pix_pos) + 1 >= npix);
    if (closes) begin
      case (kind)
        CHIP_APA102:  repeat ((npix + 15) / 16) beats.push_back(ZERO_BYTE);
        CHIP_LPD6803: repeat ((npix + 7) / 8) beats.push_back(ZERO_BYTE);
        CHIP_LPD8806: repeat ((npix + 31) / 32) beats.push_back(END_FILL_ONE);
        CHIP_P9813:   repeat (4) beats.push_back(ZERO_BYTE);
        default: ;
      endcase
      pix_pos = 8'd0;
    end else begin
      pix_pos = pix_pos + 8'd1;
    end

    foreach (beats[k]) begin
      b.wire_byte  = beats[k];
      b.frame_done = closes && (k == beats.size() - 1);
      b.item_last  = (k == chan_end) || b.frame_done;
      byte_q.push_back(b);
    end
  endtask

  // Compare one output transfer against the oldest expected byte
  task automatic check_beat();
    wire_beat_t want;
    if (byte_q.size() == 0) begin
      $error("wire byte %02h arrived with nothing expected", m_tdata);
      fails++;
    end else begin
      want = byte_q.pop_front();
      checked++;
      if (m_tdata !== want.wire_byte) begin
        $error("wire_byte: expected %02h, got %02h", want.wire_byte, m_tdata);
        fails++;
      end
      if (m_tlast !== want.frame_done) begin
        $error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
        fails++;
      end
      if (m_tuser[0] !== want.item_last) begin
        $error("item_last: expected %0b, got %0b", want.item_last, m_tuser[0]);
        fails++;
      end
    end
    if (m_tlast === 1'b1) frames++;
  endtask

  // Watch config writes, pixel and byte transfers
  always @(posedge clk) begin
    if (rst) begin
      chip_reg   = CHIP_APA102;
      bpp_reg    = 3'd3;
      count_reg  = 9'd1;
      bright_reg = 5'd31;
      pix_pos    = 8'd0;
      byte_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_CHIP_TYPE:  chip_reg   = cfg_data[2:0];
          REG_BPP:        bpp_reg    = cfg_data[2:0];
          REG_PIXEL_CNT:  count_reg  = cfg_data[8:0];
          REG_BRIGHTNESS: bright_reg = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) frame_pixel(s_tdata);
      if (m_tvalid && m_tready) check_beat();
    end
    pending       <= byte_q.size();
    fail_count    <= fails;
    bytes_checked <= checked;
    frames_closed <= frames;
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for led_strip_spi_framer_core: clock, reset, config writes,
// pixel stimulus, output back-pressure, watchdog and verdict.
// Depends on lssf_pkg, the core and lssf_frame_checker.
`timescale 1ns / 1ps

module tb;
  import lssf_pkg::*;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TOTAL_PIXELS   = 430;

  // chip codes outside the named set
  localparam logic [2:0] CHIP_ALIAS_LO  = 3'd5;
  localparam logic [2:0] CHIP_ALIAS_MID = 3'd6;
  localparam logic [2:0] CHIP_ALIAS_HI  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // channel_0, channel_1, channel_2, channel_3
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // wire_byte
  logic                  m_tlast;        // frame_done
  logic [0:0]            m_tuser;        // item_last

  int fail_count;
  int pending;
  int bytes_checked;
  int frames_closed;
  int pixels_sent;
  int gap_pct;
  int stall_pct;
  int quiet_cycles;
  bit hold_req;

  always #5 clk = ~clk;

  led_strip_spi_framer_core #(
    .MAX_PIXELS(256)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  lssf_frame_checker #(
    .MAX_PIX(256)
  ) u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  // One register write, then the port goes quiet again
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel after a random gap; returns at the transfer edge
  task automatic send_pixel(input logic [31:0] d);
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // Stop offering and wait until every expected byte has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // 0: none, 1: sender gaps, 2: receiver stalls, 3: both
  task automatic set_idle(input int mode);
    case (mode)
      1:       begin gap_pct = 61; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 61; end
      3:       begin gap_pct = 38; stall_pct = 38; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  function automatic logic [31:0] random_pixel();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h0000_0000;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
               quiet_cycles, pending);
      $display("tb: errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int n;
    int r;
    set_idle(0);
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: APA102, one pixel per frame, full brightness
    send_pixel(32'hFFFF_FFFF);

    // P9813 with two-byte pixels: header still reads channel 2
    wait_idle();
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_P9813));
    cfg_write(REG_BPP, 9'd2);
    cfg_write(REG_PIXEL_CNT, 9'd2);
    send_pixel(32'h00C0_4080);
    send_pixel(32'hFF3F_BF7F);

    // LPD6803, four-byte pixels, sender gaps
    wait_idle();
    set_idle(1);
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_LPD6803));
    cfg_write(REG_BPP, 9'd4);
    cfg_write(REG_PIXEL_CNT, 9'd3);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5A5_5A5A);

    // LPD8806, single pixel, then a frame cut short mid-way
    wait_idle();
    set_idle(2);
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_LPD8806));
    cfg_write(REG_BPP, 9'd3);
    cfg_write(REG_PIXEL_CNT, 9'd1);
    send_pixel(32'h0012_3456);
    wait_idle();
    cfg_write(REG_PIXEL_CNT, 9'd33);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    wait_idle();
    cfg_write(REG_PIXEL_CNT, 9'd2);
    send_pixel(random_pixel());

    // WS2801: raw bytes, last pixel byte closes the frame
    wait_idle();
    set_idle(3);
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_WS2801));
    cfg_write(REG_PIXEL_CNT, 9'd2);
    send_pixel(32'h5566_7788);
    send_pixel(32'h99AA_BBCC);

    // unknown chip codes, sizes out of range, zero brightness
    wait_idle();
    set_idle(0);
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_ALIAS_HI));
    cfg_write(REG_BPP, 9'd0);
    cfg_write(REG_PIXEL_CNT, 9'd0);
    cfg_write(REG_BRIGHTNESS, 9'd0);
    send_pixel(random_pixel());
    wait_idle();
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_ALIAS_LO));
    cfg_write(REG_BPP, 9'd1);
    send_pixel(random_pixel());
    wait_idle();
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_ALIAS_MID));
    cfg_write(REG_BPP, 9'd7);
    cfg_write(REG_PIXEL_CNT, 9'h1FF);
    send_pixel(random_pixel());
    // switch to APA102 and shrink the frame under the running index
    wait_idle();
    cfg_write(REG_CHIP_TYPE, 9'(CHIP_APA102));
    cfg_write(REG_PIXEL_CNT, 9'd1);
    send_pixel(random_pixel());

    // random phases; settings change only between phases
    for (int p = 0; pixels_sent < TOTAL_PIXELS; p++) begin
      wait_idle();
      set_idle(p % 4);
      if (p == 2) begin
        // one full-length APA102 frame
        cfg_write(REG_CHIP_TYPE, 9'(CHIP_APA102));
        cfg_write(REG_BPP, 9'($urandom_range(2, 4)));
        cfg_write(REG_PIXEL_CNT, 9'h1FF);
        cfg_write(REG_BRIGHTNESS, 9'($urandom_range(31)));
        n = 256;
      end else begin
        if (p == 0 || $urandom_range(3) != 0) begin
          r = $urandom_range(99);
          cfg_write(REG_CHIP_TYPE, (r < 80) ? 9'($urandom_range(4)) : 9'($urandom_range(511)));
        end
        if (p == 0 || $urandom_range(3) != 0) begin
          r = $urandom_range(99);
          cfg_write(REG_BPP, (r < 80) ? 9'($urandom_range(2, 4)) : 9'($urandom_range(511)));
        end
        if (p == 0 || $urandom_range(3) != 0) begin
          r = $urandom_range(99);
          if (r < 70) cfg_write(REG_PIXEL_CNT, 9'($urandom_range(1, 12)));
          else if (r < 90) cfg_write(REG_PIXEL_CNT, 9'($urandom_range(13, 64)));
          else cfg_write(REG_PIXEL_CNT, 9'($urandom_range(511)));
        end
        if (p == 0 || $urandom_range(3) != 0) begin
          cfg_write(REG_BRIGHTNESS, 9'($urandom_range(511)));
        end
        n = $urandom_range(4, 24);
      end
      // long output hold-off while the sender keeps offering
      if (p == 1) hold_req = 1'b1;
      repeat (n) send_pixel(random_pixel());
    end

    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d pixels in, %0d wire bytes checked, %0d frames closed",
             pixels_sent, bytes_checked, frames_closed);
    $display("run: all chip codes, pixel sizes 0..7, frame lengths 1..256, mid-frame shrink");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
